/* rtl/core/piecewise_linear_density_lookup_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise-linear density lookup
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_DENSITY_LOOKUP_ASSERT_SVH
`define PIECEWISE_LINEAR_DENSITY_LOOKUP_ASSERT_SVH

// Same-cycle implication under a synchronous reset.
`define PLD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pld check failed");

// Next-cycle implication under a synchronous reset.
`define PLD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pld check failed");

`endif

/* rtl/core/pld_pkg.sv */
// ----------------------------------------------------------------------------
// pld_pkg
// Widths, codes and types shared by the density lookup modules.
// ----------------------------------------------------------------------------
package pld_pkg;

   localparam int MAX_POINTS_DEFAULT = 16;

   localparam int HU_W    = 16;
   localparam int DENS_W  = 24;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;
   localparam int PROD_W  = HU_W + DENS_W;
   localparam int REQ_DATA_W = 48;

   localparam logic MODE_QUERY = 1'b0;
   localparam logic MODE_LOAD  = 1'b1;

   typedef struct packed {
      logic signed [HU_W-1:0] hu;
      logic [DENS_W-1:0]      dens;
   } bp_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

endpackage

/* rtl/core/pld_table.sv */
// ----------------------------------------------------------------------------
// pld_table
// Breakpoint store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pld_table
   import pld_pkg::*;
#(
   parameter int DEPTH = MAX_POINTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  bp_entry_type             wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output bp_entry_type             rd_data
);

   bp_entry_type mem [DEPTH];
   bp_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/pld_divider.sv */
// ----------------------------------------------------------------------------
// pld_divider
// Restoring radix-2 divider, one quotient bit per cycle. The quotient is
// known to fit DENS_W bits, so the upper dividend bits seed the remainder.
// ----------------------------------------------------------------------------
module pld_divider
   import pld_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PROD_W-1:0]   dividend,
   input  logic [HU_W-1:0]     divisor,
   output logic [DENS_W-1:0]   quotient,
   output div_status_type      status
);

   localparam int STEP_W = $clog2(DENS_W);

   logic [HU_W-1:0]   rem_ff, rem_in;
   logic [DENS_W-1:0] sh_ff, sh_in;
   logic [HU_W-1:0]   den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      logic [HU_W:0] trial;
      logic          fits;
      trial   = {rem_ff, sh_ff[DENS_W-1]};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[PROD_W-1:DENS_W];
         sh_in   = dividend[DENS_W-1:0];
         den_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (fits) begin
            rem_in = HU_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[HU_W-1:0];
         end
         sh_in   = {sh_ff[DENS_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DENS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
   end

   assign quotient    = sh_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* rtl/core/piecewise_linear_density_lookup.sv */
// Load transaction: written to the table in the accept cycle, next one taken right after.
// Query path: every breakpoint scanned passes ST_SCAN then ST_CHECK on the single
//   table read port; a bracketed hit then runs ST_MUL, ST_DIV_GO and ST_DIV_WAIT.
// Out-of-range and first-breakpoint hits skip the multiply and divide.
// Reset: control cleared, point_count back to 1; table contents are kept, not cleared.
// ----------------------------------------------------------------------------
// piecewise_linear_density_lookup
// HU to density by linear interpolation over a loadable breakpoint table,
// with a sequential search and an iterative divider.
// ----------------------------------------------------------------------------
module piecewise_linear_density_lookup
   import pld_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration: point_count
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COUNT_W-1:0]    csr_data,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // hu[15:0], index[19:16], density_value[43:20]
   input  logic                  req_tuser,  // mode
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DENS_W-1:0]     rsp_tdata,  // density[23:0]
   output logic                  rsp_tuser   // out_of_range
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]     point_count_ff, point_count_in;
   logic signed [HU_W-1:0] x_ff, x_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic signed [HU_W-1:0] x1_ff, x1_in;
   logic signed [HU_W-1:0] x2_ff, x2_in;
   logic [DENS_W-1:0]      y1_ff, y1_in;
   logic [HU_W-1:0]        dx_ff, dx_in;
   logic [HU_W-1:0]        den_ff, den_in;
   logic [DENS_W-1:0]      mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [DENS_W-1:0]      res_dens_ff, res_dens_in;
   logic                   res_oor_ff, res_oor_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DENS_W-1:0]      rsp_dens_ff, rsp_dens_in;
   logic                   rsp_oor_ff, rsp_oor_in;

   logic                   req_accept;
   logic signed [HU_W-1:0] req_hu;
   logic [INDEX_W-1:0]     req_index;
   logic [DENS_W-1:0]      req_dens;

   logic                   tbl_wr_en;
   bp_entry_type           tbl_wr_data;
   logic                   tbl_rd_en;
   bp_entry_type           tbl_rd_data;

   logic                   div_start;
   logic [DENS_W-1:0]      div_quot;
   div_status_type         div_status;

   logic                   rsp_free;

   assign req_hu     = req_tdata[HU_W-1:0];
   assign req_index  = req_tdata[HU_W+INDEX_W-1:HU_W];
   assign req_dens   = req_tdata[HU_W+INDEX_W+DENS_W-1:HU_W+INDEX_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign tbl_wr_en        = req_accept && (req_tuser == MODE_LOAD) &&
                             (32'(req_index) < MAX_POINTS);
   assign tbl_wr_data.hu   = req_hu;
   assign tbl_wr_data.dens = req_dens;
   assign tbl_rd_en        = (state_ff == ST_SCAN);

   pld_table #(
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (ADDR_W'(req_index)),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   pld_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .quotient (div_quot),
      .status   (div_status)
   );

   always_comb begin
      logic signed [HU_W:0]   diff_x;
      logic signed [HU_W:0]   diff_den;
      logic signed [DENS_W:0] dy;
      logic signed [DENS_W:0] dy_neg;
      logic                   hit;
      diff_x   = 17'(x_ff) - 17'(x1_ff);
      diff_den = 17'(tbl_rd_data.hu) - 17'(x1_ff);
      dy       = {1'b0, tbl_rd_data.dens} - {1'b0, y1_ff};
      dy_neg   = -dy;
      hit      = tbl_rd_data.hu >= x_ff;

      state_in       = state_ff;
      point_count_in = point_count_ff;
      x_in           = x_ff;
      n_in           = n_ff;
      idx_in         = idx_ff;
      x1_in          = x1_ff;
      x2_in          = x2_ff;
      y1_in          = y1_ff;
      dx_in          = dx_ff;
      den_in         = den_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      prod_in        = prod_ff;
      res_dens_in    = res_dens_ff;
      res_oor_in     = res_oor_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_dens_in    = rsp_dens_ff;
      rsp_oor_in     = rsp_oor_ff;
      div_start      = 1'b0;

      if (csr_valid && csr_ready) begin
         point_count_in = csr_data;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == MODE_QUERY)) begin
               x_in   = req_hu;
               idx_in = '0;
               // zero means one breakpoint, clamp at the table depth
               if (point_count_ff == '0) begin
                  n_in = CNT_W'(1);
               end else if (32'(point_count_ff) > MAX_POINTS) begin
                  n_in = CNT_W'(MAX_POINTS);
               end else begin
                  n_in = CNT_W'(point_count_ff);
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (hit) begin
               if (idx_ff == '0) begin
                  res_oor_in  = (tbl_rd_data.hu != x_ff);
                  res_dens_in = (tbl_rd_data.hu == x_ff) ? tbl_rd_data.dens : '0;
                  state_in    = ST_DONE;
               end else begin
                  x2_in    = tbl_rd_data.hu;
                  dx_in    = diff_x[HU_W-1:0];
                  den_in   = diff_den[HU_W-1:0];
                  neg_in   = dy[DENS_W];
                  mag_in   = dy[DENS_W] ? dy_neg[DENS_W-1:0] : dy[DENS_W-1:0];
                  state_in = ST_MUL;
               end
            end else begin
               // slide the window: this entry becomes the lower neighbor
               x1_in = tbl_rd_data.hu;
               y1_in = tbl_rd_data.dens;
               if (CNT_W'(idx_ff + 1'b1) == n_ff) begin
                  res_oor_in  = 1'b1;
                  res_dens_in = '0;
                  state_in    = ST_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(dx_ff) * PROD_W'(mag_ff);
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               res_dens_in = neg_ff ? (y1_ff - div_quot) : (y1_ff + div_quot);
               res_oor_in  = 1'b0;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_dens_in  = res_dens_ff;
               rsp_oor_in   = res_oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= COUNT_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
      y1_ff       <= y1_in;
      dx_ff       <= dx_in;
      den_ff      <= den_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      res_dens_ff <= res_dens_in;
      res_oor_ff  <= res_oor_in;
      rsp_dens_ff <= rsp_dens_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_dens_ff;
   assign rsp_tuser  = rsp_oor_ff;

   `include "piecewise_linear_density_lookup_assert.svh"

   `PLD_ASSERT_IMP(a_done_only_waiting, clock, reset, div_status.done, state_ff == ST_DIV_WAIT)
   `PLD_ASSERT_IMP(a_oor_zero_density, clock, reset, rsp_valid_ff && rsp_oor_ff, rsp_dens_ff == '0)
   `PLD_ASSERT_IMP(a_mul_bracketed, clock, reset, state_ff == ST_MUL, (x1_ff < x_ff) && (x_ff <= x2_ff))
   `PLD_ASSERT_NXT(a_load_stays_idle, clock, reset, req_accept && (req_tuser == MODE_LOAD), state_ff == ST_IDLE)

endmodule

/* tb/piecewise_linear_density_lookup_checker.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_density_lookup_checker
// Watches the configuration, request and response channels of the density
// lookup, keeps its own copy of the breakpoint table and point count, works
// out the density for every accepted query and compares each response
// transaction with the oldest outstanding one.
// ----------------------------------------------------------------------------
module piecewise_linear_density_lookup_checker
   import pld_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [COUNT_W-1:0]    csr_data,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // hu[15:0], index[19:16], density_value[43:20]
   input  logic                  req_tuser,  // mode
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [DENS_W-1:0]     rsp_tdata,  // density[23:0]
   input  logic                  rsp_tuser,  // out_of_range
   input  logic                  final_check,
   output int                    pending,
   output int                    mismatch_count,
   output int                    results_checked,
   output int                    out_of_range_seen
);

   localparam int TABLE_DEPTH = MAX_POINTS_DEFAULT;
   localparam int REPORT_LIMIT = 40;

   typedef struct packed {
      logic [DENS_W-1:0] density;
      logic              out_of_range;
   } density_result_type;

   logic signed [HU_W-1:0] bp_hu [TABLE_DEPTH];
   logic [DENS_W-1:0]      bp_dens [TABLE_DEPTH];
   logic [COUNT_W-1:0]     count_setting;
   density_result_type     pending_densities [$];
   density_result_type     oldest;

   initial begin
      pending = 0;
      mismatch_count = 0;
      results_checked = 0;
      out_of_range_seen = 0;
      count_setting = COUNT_W'(1);
   end

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] density lookup mismatch: %s", $time, what);
      end
   endtask

   // Search the table in slot order for the first breakpoint at or above x.
   function automatic density_result_type interpolate_density(logic signed [HU_W-1:0] x);
      density_result_type res;
      int     used;
      int     hit;
      longint x1, x2, y1, y2, q;
      res.density = '0;
      res.out_of_range = 1'b1;
      used = (count_setting == 0) ? 1 :
             (count_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_setting);
      hit = -1;
      for (int i = 0; i < used; i++) begin
         if (hit < 0 && bp_hu[i] >= x) hit = i;
      end
      if (hit == 0) begin
         if (bp_hu[0] == x) begin
            res.density = bp_dens[0];
            res.out_of_range = 1'b0;
         end
      end else if (hit > 0) begin
         x1 = bp_hu[hit-1];
         x2 = bp_hu[hit];
         y1 = bp_dens[hit-1];
         y2 = bp_dens[hit];
         // signed division truncates toward zero; x1 < x <= x2 keeps the divisor positive
         q = y1 + (longint'(x) - x1) * (y2 - y1) / (x2 - x1);
         res.density = DENS_W'(q);
         res.out_of_range = 1'b0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         count_setting = COUNT_W'(1);
         pending_densities.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (rsp_tuser) out_of_range_seen++;
            if (pending_densities.size() == 0) begin
               report_mismatch($sformatf("unrequested result density=%h out_of_range=%b",
                                         rsp_tdata, rsp_tuser));
            end else begin
               oldest = pending_densities.pop_front();
               if (rsp_tdata !== oldest.density) begin
                  report_mismatch($sformatf("density got %h want %h",
                                            rsp_tdata, oldest.density));
               end
               if (rsp_tuser !== oldest.out_of_range) begin
                  report_mismatch($sformatf("out_of_range got %b want %b",
                                            rsp_tuser, oldest.out_of_range));
               end
            end
         end
         if (csr_valid && csr_ready) count_setting = csr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser == MODE_LOAD) begin
               bp_hu[req_tdata[HU_W +: INDEX_W]] = req_tdata[HU_W-1:0];
               bp_dens[req_tdata[HU_W +: INDEX_W]] = req_tdata[HU_W+INDEX_W +: DENS_W];
            end else begin
               pending_densities.push_back(interpolate_density(req_tdata[HU_W-1:0]));
            end
         end
         if (final_check && pending_densities.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived",
                                      pending_densities.size()));
         end
      end
      pending <= pending_densities.size();
   end

endmodule

/* tb/piecewise_linear_density_lookup_tb.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_density_lookup_tb
// Drives breakpoint loads, density queries and point_count writes into the
// lookup with random gaps and response backpressure. A short directed part
// covers exact hits, both out-of-range sides, count zero and an unsorted
// table; random phases follow, saturating counts among them, with fresh tables per setting.
// ----------------------------------------------------------------------------
module piecewise_linear_density_lookup_tb;
   import pld_pkg::*;

   localparam int TABLE_DEPTH   = MAX_POINTS_DEFAULT;
   localparam int ITEM_TARGET   = 1200;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 80;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int RUN_LIMIT     = 10_000_000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_W-1:0]    csr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // hu[15:0], index[19:16], density_value[43:20]
   logic                  req_tuser = 1'b0; // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DENS_W-1:0]     rsp_tdata;        // density[23:0]
   logic                  rsp_tuser;        // out_of_range
   logic                  final_check = 1'b0;

   int pending;
   int mismatch_count;
   int results_checked;
   int out_of_range_seen;

   int items_sent = 0;
   int loads_sent = 0;
   int queries_sent = 0;
   int settings_written = 0;
   logic steady_phase = 1'b0;
   logic signed [HU_W-1:0] loaded_hu [TABLE_DEPTH];

   piecewise_linear_density_lookup dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   piecewise_linear_density_lookup_checker density_check (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .final_check       (final_check),
      .pending           (pending),
      .mismatch_count    (mismatch_count),
      .results_checked   (results_checked),
      .out_of_range_seen (out_of_range_seen)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #(RUN_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // Response backpressure: mostly short stalls, a few long ones, and long
   // stretches of steady ready.
   initial begin : rsp_backpressure
      int roll;
      int span;
      @(posedge clock);
      forever begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            rsp_tready <= 1'b1;
            span = $urandom_range(100, 300);
         end else if (roll < 65) begin
            rsp_tready <= 1'b1;
            span = $urandom_range(1, 8);
         end else if (roll < 92) begin
            rsp_tready <= 1'b0;
            span = $urandom_range(1, 3);
         end else begin
            rsp_tready <= 1'b0;
            span = $urandom_range(15, 40);
         end
         repeat (span) @(posedge clock);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_phase || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Called at a rising edge; returns at the edge where the transaction is taken.
   task automatic send_item(logic mode, logic signed [HU_W-1:0] hu,
                            logic [INDEX_W-1:0] slot, logic [DENS_W-1:0] dens);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0, dens, slot, hu};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      items_sent++;
      if (mode == MODE_LOAD) begin
         loaded_hu[slot] = hu;
         loads_sent++;
      end else begin
         queries_sent++;
      end
   endtask

   task automatic load_point(logic [INDEX_W-1:0] slot, logic signed [HU_W-1:0] hu,
                             logic [DENS_W-1:0] dens);
      send_item(MODE_LOAD, hu, slot, dens);
   endtask

   task automatic query_density(logic signed [HU_W-1:0] hu);
      send_item(MODE_QUERY, hu, INDEX_W'($urandom), DENS_W'($urandom));
   endtask

   // Hold off until every query is answered, then write the count.
   task automatic write_point_count(logic [COUNT_W-1:0] value);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   task automatic directed_cases();
      // single breakpoint at reset count: exact hit and above the table
      load_point(4'd0, -16'sd32768, 24'h000000);
      query_density(-16'sd32768);
      query_density(-16'sd32767);
      // count zero behaves as one breakpoint
      write_point_count(COUNT_W'(0));
      load_point(4'd0, 16'sd100, 24'hFFFFFF);
      query_density(16'sd100);
      query_density(16'sd99);
      // unsorted three-point table, falling density, top HU extreme
      write_point_count(COUNT_W'(3));
      load_point(4'd1, -16'sd5, 24'h800000);
      load_point(4'd2, 16'sd32767, 24'h000000);
      query_density(16'sd50);
      query_density(16'sd200);
      query_density(16'sd32767);
      query_density(16'sd32766);
      query_density(16'sd100);
      query_density(-16'sd32768);
      query_density(16'sd0);
   endtask

   function automatic int planned_count(int phase);
      case (phase)
         0: return 16;
         1: return 31;
         2: return 2;
         3: return 0;
         4: return 1;
         5: return 17;
         default: begin
            if ($urandom_range(0, 19) == 0) return 0;
            if ($urandom_range(0, 9) < 4) return $urandom_range(16, 31);
            return $urandom_range(1, 15);
         end
      endcase
   endfunction

   // Mostly sorted tables (wide or narrow HU span), now and then unsorted.
   task automatic load_table(int used);
      int vals [TABLE_DEPTH];
      int order [TABLE_DEPTH];
      int shape, spread, base, tmp, j;
      logic [DENS_W-1:0] dens;
      shape = $urandom_range(0, 9);
      spread = (shape == 7 || shape == 8) ? $urandom_range(used, 200) : 65535;
      base = -32768 + int'($urandom_range(0, 65535 - spread));
      for (int i = 0; i < used; i++) begin
         vals[i] = base + int'($urandom_range(0, spread));
         order[i] = i;
      end
      if (shape < 7 && $urandom_range(0, 4) == 0) vals[0] = -32768;
      if (shape < 7 && $urandom_range(0, 4) == 0) vals[used-1] = 32767;
      if (shape < 9) begin
         for (int i = 1; i < used; i++) begin
            tmp = vals[i];
            j = i - 1;
            while (j >= 0 && vals[j] > tmp) begin
               vals[j+1] = vals[j];
               j--;
            end
            vals[j+1] = tmp;
         end
         for (int i = 1; i < used; i++) begin
            if (vals[i] <= vals[i-1] && vals[i-1] < 32767) vals[i] = vals[i-1] + 1;
         end
      end
      // load the slots in random order
      for (int i = used - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < used; i++) begin
         case ($urandom_range(0, 9))
            0: dens = '0;
            1: dens = '1;
            default: dens = DENS_W'($urandom);
         endcase
         load_point(INDEX_W'(order[i]), HU_W'(vals[order[i]]), dens);
      end
   endtask

   function automatic logic signed [HU_W-1:0] pick_query(int used);
      int roll, k, lo, hi;
      roll = $urandom_range(0, 99);
      k = $urandom_range(0, used - 1);
      lo = loaded_hu[(k > 0) ? k - 1 : 0];
      hi = loaded_hu[k];
      if (roll < 30) return loaded_hu[k];
      if (roll < 60 && lo < hi) return HU_W'(lo + int'($urandom_range(0, hi - lo)));
      if (roll < 70) return loaded_hu[k] + (($urandom_range(0, 1) == 1) ? 16'sd1 : -16'sd1);
      if (roll < 80) return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
      return HU_W'($urandom);
   endfunction

   task automatic random_phase(int phase);
      int setting, used, queries;
      setting = planned_count(phase);
      write_point_count(COUNT_W'(setting));
      used = (setting == 0) ? 1 : (setting > TABLE_DEPTH) ? TABLE_DEPTH : setting;
      steady_phase = ($urandom_range(0, 3) == 0);
      load_table(used);
      queries = $urandom_range(20, 60);
      repeat (queries) begin
         // occasional stray load overwrites a slot and may break the order
         if ($urandom_range(0, 99) < 8) begin
            load_point(INDEX_W'($urandom), HU_W'($urandom), DENS_W'($urandom));
         end else begin
            query_density(pick_query(used));
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      int guard;
      phase = 0;
      guard = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_cases();
      while (items_sent < ITEM_TARGET) begin
         random_phase(phase);
         phase++;
      end
      steady_phase = 1'b0;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0 && guard < DRAIN_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      final_check <= 1'b1;
      @(posedge clock);
      final_check <= 1'b0;
      @(posedge clock);
      $display("Covered %0d breakpoint loads and %0d density queries over %0d count settings.",
               loads_sent, queries_sent, settings_written);
      $display("Checked %0d results, %0d of them flagged out of range.",
               results_checked, out_of_range_seen);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
